// File: hw/rtl/euler_look_direction_unit_assert.svh
// Assertion macros for the look direction unit checker.
// Depends on nothing; included by the checker file.
`ifndef EULER_LOOK_DIRECTION_UNIT_ASSERT_SVH
`define EULER_LOOK_DIRECTION_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is low.
`define ELDU_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("look direction unit assertion failed");

// Clocked assertion that also holds while reset is low.
`define ELDU_ASSERT_RST(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) (prop)) \
        else $error("look direction unit reset assertion failed");

`endif

// File: hw/rtl/eldu_pkg.sv
// Shared constants, types and tables of the look direction unit.
// Used by the controller, datapath and top level.
`default_nettype none
package eldu_pkg;

    localparam logic [1:0] CMD_LOOK      = 2'd0;
    localparam logic [1:0] CMD_SET_YAW   = 2'd1;
    localparam logic [1:0] CMD_SET_PITCH = 2'd2;

    localparam int PADDR_W = 3;
    localparam logic REG_LOOK_GAIN = 1'b0;
    localparam logic [15:0] LOOK_GAIN_RESET = 16'd6554;

    localparam logic signed [31:0] DEG90     = 32'sd5898240;
    localparam logic signed [31:0] DEG180    = 32'sd11796480;
    localparam logic signed [31:0] DEG270    = 32'sd17694720;
    localparam logic signed [31:0] DEG360    = 32'sd23592960;
    localparam logic signed [31:0] PITCH_LIM = 32'sd5898174;
    localparam logic signed [32:0] CORDIC_K  = 33'sd652032875;

    localparam int CORDIC_N  = 17;
    localparam int MOD_STEPS = 7;
    localparam int CNT_W     = 5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_MOD, ST_WRAP, ST_CORD, ST_FIX, ST_PROD, ST_OUT
    } state_t;

    typedef struct packed {
        logic             latch;
        logic             mul;
        logic             acc;
        logic             mod_step;
        logic             wrap;
        logic             cord_step;
        logic             fix;
        logic             prod;
        logic             out_load;
        logic [CNT_W-1:0] step;
    } dp_cmd_t;

    // CORDIC arctangent table, degrees Q16.16
    function automatic logic signed [25:0] atan_deg(input logic [CNT_W-1:0] i);
        unique case (i)
            5'd0:    atan_deg = 26'sd2949120;
            5'd1:    atan_deg = 26'sd1740967;
            5'd2:    atan_deg = 26'sd919879;
            5'd3:    atan_deg = 26'sd466945;
            5'd4:    atan_deg = 26'sd234379;
            5'd5:    atan_deg = 26'sd117304;
            5'd6:    atan_deg = 26'sd58666;
            5'd7:    atan_deg = 26'sd29335;
            5'd8:    atan_deg = 26'sd14668;
            5'd9:    atan_deg = 26'sd7334;
            5'd10:   atan_deg = 26'sd3667;
            5'd11:   atan_deg = 26'sd1833;
            5'd12:   atan_deg = 26'sd917;
            5'd13:   atan_deg = 26'sd458;
            5'd14:   atan_deg = 26'sd229;
            5'd15:   atan_deg = 26'sd115;
            5'd16:   atan_deg = 26'sd57;
            default: atan_deg = 26'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/euler_look_direction_unit.sv
// Top level of the look direction unit: APB register, controller, datapath.
// Depends on eldu_pkg, eldu_ctrl and eldu_dp.
//
//  channel | signals                       | transfer when
//  input   | in_valid, in_ready, payload   | in_valid && in_ready
//  output  | out_valid, out_ready, payload | out_valid && out_ready
//  config  | psel, penable, pwrite, paddr  | psel && penable && pwrite
//
// After the input transfer the sequencer steps through multiply, accumulate,
// 7 steps of the modulo-360 subtract unit, fold, 17 CORDIC steps (yaw and
// pitch side by side), sign fix, products and output load; out_valid rises once
// the output register is loaded, and the sequencer idles before the next item.
// One item is in flight at a time; in_ready is high only while the sequencer idles.
// A result waits in the output register while out_ready is low; the next item
// may be accepted meanwhile but holds in its last step until the register frees.
// Reset clears the angles to zero and look_gain to 6554.
`default_nettype none
module euler_look_direction_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [eldu_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   command,
    input  wire logic signed [15:0]           delta_x,
    input  wire logic signed [15:0]           delta_y,
    input  wire logic                         clamp_enable,
    input  wire logic signed [31:0]           angle_value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [31:0]                yaw_out,
    output logic signed [31:0]                pitch_out,
    output logic signed [15:0]                front_x,
    output logic signed [15:0]                front_y,
    output logic signed [15:0]                front_z,
    output logic signed [15:0]                right_x,
    output logic signed [15:0]                right_y,
    output logic signed [15:0]                right_z,
    output logic signed [15:0]                up_x,
    output logic signed [15:0]                up_y,
    output logic signed [15:0]                up_z,
    output logic                              degenerate
);

    logic [15:0]        look_gain_reg;
    logic               gain_sel;
    eldu_pkg::dp_cmd_t  dp_cmd;

    // register index is the word address; only index zero exists
    assign gain_sel = (paddr[2] == eldu_pkg::REG_LOOK_GAIN);
    assign pready   = 1'b1;
    assign prdata   = gain_sel ? {16'd0, look_gain_reg} : 32'd0;

    // write on the access phase; drop writes to unknown addresses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            look_gain_reg <= eldu_pkg::LOOK_GAIN_RESET;
        else if (psel && penable && pwrite && pready && gain_sel)
            look_gain_reg <= pwdata[15:0];
    end

    eldu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd)
    );

    eldu_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .look_gain    (look_gain_reg),
        .command      (command),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .clamp_enable (clamp_enable),
        .angle_value  (angle_value),
        .yaw_out      (yaw_out),
        .pitch_out    (pitch_out),
        .front_x      (front_x),
        .front_y      (front_y),
        .front_z      (front_z),
        .right_x      (right_x),
        .right_y      (right_y),
        .right_z      (right_z),
        .up_x         (up_x),
        .up_y         (up_y),
        .up_z         (up_z),
        .degenerate   (degenerate)
    );

endmodule
`default_nettype wire

// File: hw/rtl/eldu_ctrl.sv
// Sequencer of the look direction unit: state machine, step counter, output valid.
// Depends on eldu_pkg.
`default_nettype none
module eldu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output eldu_pkg::dp_cmd_t      dp_cmd
);

    eldu_pkg::state_t state_reg, state_next;
    logic [eldu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eldu_pkg::ST_IDLE: if (in_valid) state_next = eldu_pkg::ST_MUL;
            eldu_pkg::ST_MUL:  state_next = eldu_pkg::ST_ACC;
            eldu_pkg::ST_ACC:  state_next = eldu_pkg::ST_MOD;
            eldu_pkg::ST_MOD:
                if (cnt_reg == eldu_pkg::CNT_W'(eldu_pkg::MOD_STEPS - 1))
                    state_next = eldu_pkg::ST_WRAP;
            eldu_pkg::ST_WRAP: state_next = eldu_pkg::ST_CORD;
            eldu_pkg::ST_CORD:
                if (cnt_reg == eldu_pkg::CNT_W'(eldu_pkg::CORDIC_N - 1))
                    state_next = eldu_pkg::ST_FIX;
            eldu_pkg::ST_FIX:  state_next = eldu_pkg::ST_PROD;
            eldu_pkg::ST_PROD: state_next = eldu_pkg::ST_OUT;
            eldu_pkg::ST_OUT:  if (out_free) state_next = eldu_pkg::ST_IDLE;
            default:           state_next = eldu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (state_next != state_reg)
            cnt_next = '0;
        else
            cnt_next = cnt_reg + 1'b1;
    end

    always_comb
    begin
        dp_cmd           = '0;
        dp_cmd.step      = cnt_reg;
        in_ready         = (state_reg == eldu_pkg::ST_IDLE);
        dp_cmd.latch     = in_ready && in_valid;
        dp_cmd.mul       = (state_reg == eldu_pkg::ST_MUL);
        dp_cmd.acc       = (state_reg == eldu_pkg::ST_ACC);
        dp_cmd.mod_step  = (state_reg == eldu_pkg::ST_MOD);
        dp_cmd.wrap      = (state_reg == eldu_pkg::ST_WRAP);
        dp_cmd.cord_step = (state_reg == eldu_pkg::ST_CORD);
        dp_cmd.fix       = (state_reg == eldu_pkg::ST_FIX);
        dp_cmd.prod      = (state_reg == eldu_pkg::ST_PROD);
        dp_cmd.out_load  = (state_reg == eldu_pkg::ST_OUT) && out_free;
    end

    always_comb
    begin
        if (dp_cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eldu_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/eldu_dp.sv
// Datapath of the look direction unit: angle state, modulo unit, two CORDICs,
// products and output registers. Depends on eldu_pkg.
`default_nettype none
module eldu_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire eldu_pkg::dp_cmd_t  dp_cmd,
    input  wire logic [15:0]        look_gain,
    input  wire logic [1:0]         command,
    input  wire logic signed [15:0] delta_x,
    input  wire logic signed [15:0] delta_y,
    input  wire logic               clamp_enable,
    input  wire logic signed [31:0] angle_value,
    output logic signed [31:0]      yaw_out,
    output logic signed [31:0]      pitch_out,
    output logic signed [15:0]      front_x,
    output logic signed [15:0]      front_y,
    output logic signed [15:0]      front_z,
    output logic signed [15:0]      right_x,
    output logic signed [15:0]      right_y,
    output logic signed [15:0]      right_z,
    output logic signed [15:0]      up_x,
    output logic signed [15:0]      up_y,
    output logic signed [15:0]      up_z,
    output logic                    degenerate
);

    localparam logic [31:0] DEG360_U = 32'(eldu_pkg::DEG360);

    function automatic logic signed [15:0] clamp_q14(input logic signed [33:0] r);
        if (r > 34'sd16384)
            clamp_q14 = 16'sd16384;
        else if (r < -34'sd16384)
            clamp_q14 = -16'sd16384;
        else
            clamp_q14 = 16'(r);
    endfunction

    // round Q2.60 to Q2.14, half up
    function automatic logic signed [15:0] round_prod(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + (64'sd1 <<< 45)) >>> 46;
        round_prod = clamp_q14(34'(t));
    endfunction

    // round Q1.30 to Q2.14, half up
    function automatic logic signed [15:0] round_term(input logic signed [32:0] v);
        logic signed [33:0] t;
        t = ($signed({v[32], v}) + 34'sd32768) >>> 16;
        round_term = clamp_q14(t);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
        if (s > 34'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (s < -34'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = 32'(s);
    endfunction

    // reduced angle in [0, 360) from sign and magnitude below 360
    function automatic logic signed [25:0] reduce(input logic neg, input logic [31:0] m);
        if (neg && m != 32'd0)
            reduce = 26'(DEG360_U - m);
        else
            reduce = 26'(m);
    endfunction

    logic [1:0]         cmd_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic               clamp_reg;
    logic signed [31:0] angle_reg;
    logic signed [32:0] prod_x_reg, prod_y_reg;
    logic signed [31:0] yaw_reg, yaw_next, pitch_reg, pitch_next;
    logic [31:0]        ym_reg, ym_next, pm_reg, pm_next;
    logic               neg_y_reg, neg_p_reg, sgn_neg_reg, degen_reg;
    logic signed [32:0] xy_reg, yy_reg, xp_reg, yp_reg;
    logic signed [25:0] zy_reg, zp_reg;
    logic signed [63:0] cycp_reg, sycp_reg, cysp_reg, sysp_reg;

    logic signed [33:0] sum_y, sum_p;
    logic signed [31:0] pitch_sat;
    logic [31:0]        mod_sub;
    logic signed [25:0] ry, rp, atan_i;
    logic signed [31:0] yaw_w;

    always_comb
    begin
        sum_y     = {{2{yaw_reg[31]}}, yaw_reg} + {prod_x_reg[32], prod_x_reg};
        sum_p     = {{2{pitch_reg[31]}}, pitch_reg} + {prod_y_reg[32], prod_y_reg};
        pitch_sat = sat32(sum_p);
        yaw_next   = yaw_reg;
        pitch_next = pitch_reg;
        unique case (cmd_reg)
            eldu_pkg::CMD_LOOK:
            begin
                yaw_next   = sat32(sum_y);
                pitch_next = pitch_sat;
                if (clamp_reg && pitch_sat > eldu_pkg::PITCH_LIM)
                    pitch_next = eldu_pkg::PITCH_LIM;
                else if (clamp_reg && pitch_sat < -eldu_pkg::PITCH_LIM)
                    pitch_next = -eldu_pkg::PITCH_LIM;
            end
            eldu_pkg::CMD_SET_YAW:   yaw_next = angle_reg;
            eldu_pkg::CMD_SET_PITCH: pitch_next = angle_reg;
            default:                 ;
        endcase
    end

    // one conditional subtract of 360 * 2^k per step, k from six down to zero
    always_comb
    begin
        mod_sub = DEG360_U << (3'(eldu_pkg::MOD_STEPS - 1) - dp_cmd.step[2:0]);
        ym_next = (ym_reg >= mod_sub) ? ym_reg - mod_sub : ym_reg;
        pm_next = (pm_reg >= mod_sub) ? pm_reg - mod_sub : pm_reg;
    end

    always_comb
    begin
        ry     = reduce(yaw_reg[31], ym_reg);
        rp     = reduce(pitch_reg[31], pm_reg);
        yaw_w  = yaw_reg[31] ? 32'(-ym_reg) : 32'(ym_reg);
        atan_i = eldu_pkg::atan_deg(dp_cmd.step);
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.latch)
        begin
            cmd_reg   <= command;
            dx_reg    <= delta_x;
            dy_reg    <= delta_y;
            clamp_reg <= clamp_enable;
            angle_reg <= angle_value;
        end
        if (dp_cmd.mul)
        begin
            prod_x_reg <= dx_reg * $signed({1'b0, look_gain});
            prod_y_reg <= dy_reg * $signed({1'b0, look_gain});
        end
        if (dp_cmd.mod_step)
        begin
            ym_reg <= ym_next;
            pm_reg <= pm_next;
        end
        if (dp_cmd.acc)
        begin
            ym_reg <= yaw_next[31] ? 32'(-yaw_next) : 32'(yaw_next);
            pm_reg <= pitch_next[31] ? 32'(-pitch_next) : 32'(pitch_next);
        end
        if (dp_cmd.wrap)
        begin
            // fold into [-90, 90] and mark a sign flip for (90, 270)
            xy_reg <= eldu_pkg::CORDIC_K;
            yy_reg <= '0;
            xp_reg <= eldu_pkg::CORDIC_K;
            yp_reg <= '0;
            neg_y_reg <= 1'b0;
            neg_p_reg <= 1'b0;
            if (ry <= 26'(eldu_pkg::DEG90))
                zy_reg <= ry;
            else if (ry < 26'(eldu_pkg::DEG270))
            begin
                zy_reg    <= ry - 26'(eldu_pkg::DEG180);
                neg_y_reg <= 1'b1;
            end
            else
                zy_reg <= ry - 26'(eldu_pkg::DEG360);
            if (rp <= 26'(eldu_pkg::DEG90))
                zp_reg <= rp;
            else if (rp < 26'(eldu_pkg::DEG270))
            begin
                zp_reg    <= rp - 26'(eldu_pkg::DEG180);
                neg_p_reg <= 1'b1;
            end
            else
                zp_reg <= rp - 26'(eldu_pkg::DEG360);
            degen_reg   <= (rp == 26'(eldu_pkg::DEG90)) || (rp == 26'(eldu_pkg::DEG270));
            sgn_neg_reg <= (rp > 26'(eldu_pkg::DEG90)) && (rp < 26'(eldu_pkg::DEG270));
        end
        if (dp_cmd.cord_step)
        begin
            if (!zy_reg[25])
            begin
                xy_reg <= xy_reg - (yy_reg >>> dp_cmd.step);
                yy_reg <= yy_reg + (xy_reg >>> dp_cmd.step);
                zy_reg <= zy_reg - atan_i;
            end
            else
            begin
                xy_reg <= xy_reg + (yy_reg >>> dp_cmd.step);
                yy_reg <= yy_reg - (xy_reg >>> dp_cmd.step);
                zy_reg <= zy_reg + atan_i;
            end
            if (!zp_reg[25])
            begin
                xp_reg <= xp_reg - (yp_reg >>> dp_cmd.step);
                yp_reg <= yp_reg + (xp_reg >>> dp_cmd.step);
                zp_reg <= zp_reg - atan_i;
            end
            else
            begin
                xp_reg <= xp_reg + (yp_reg >>> dp_cmd.step);
                yp_reg <= yp_reg - (xp_reg >>> dp_cmd.step);
                zp_reg <= zp_reg + atan_i;
            end
        end
        if (dp_cmd.fix)
        begin
            if (neg_y_reg)
            begin
                xy_reg <= -xy_reg;
                yy_reg <= -yy_reg;
            end
            if (neg_p_reg)
            begin
                xp_reg <= -xp_reg;
                yp_reg <= -yp_reg;
            end
            if (degen_reg)
                sgn_neg_reg <= 1'b0;
        end
        if (dp_cmd.prod)
        begin
            cycp_reg <= 64'(xy_reg) * 64'(xp_reg);
            sycp_reg <= 64'(yy_reg) * 64'(xp_reg);
            cysp_reg <= 64'(xy_reg) * 64'(yp_reg);
            sysp_reg <= 64'(yy_reg) * 64'(yp_reg);
        end
        if (dp_cmd.out_load)
        begin
            yaw_out    <= yaw_reg;
            pitch_out  <= pitch_reg;
            front_x    <= round_prod(cycp_reg);
            front_y    <= round_term(yp_reg);
            front_z    <= round_prod(sycp_reg);
            right_x    <= round_term(sgn_neg_reg ? yy_reg : -yy_reg);
            right_y    <= '0;
            right_z    <= round_term(sgn_neg_reg ? -xy_reg : xy_reg);
            up_x       <= round_prod(sgn_neg_reg ? cysp_reg : -cysp_reg);
            up_y       <= round_term(sgn_neg_reg ? -xp_reg : xp_reg);
            up_z       <= round_prod(sgn_neg_reg ? sysp_reg : -sysp_reg);
            degenerate <= degen_reg;
        end
    end

    // angle state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
        end
        else if (dp_cmd.acc)
        begin
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
        end
        else if (dp_cmd.wrap && cmd_reg == eldu_pkg::CMD_LOOK)
            yaw_reg <= yaw_w;
    end

endmodule
`default_nettype wire

// File: hw/rtl/eldu_checker.sv
// Port-level checker of the look direction unit, bound to the top level.
// Depends on euler_look_direction_unit_assert.svh.
`default_nettype none
`include "euler_look_direction_unit_assert.svh"
module eldu_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] yaw_out,
    input wire logic signed [15:0] right_y
);

    `ELDU_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
    `ELDU_ASSERT(a_yaw_hold, clk, rst_n, out_valid && !out_ready |=> $stable(yaw_out))
    `ELDU_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready)
    `ELDU_ASSERT(a_right_flat, clk, rst_n, out_valid |-> right_y == 16'sd0)
    `ELDU_ASSERT_RST(a_rst_quiet, clk, !rst_n |-> !out_valid)

endmodule

bind euler_look_direction_unit eldu_checker u_eldu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .yaw_out   (yaw_out),
    .right_y   (right_y)
);
`default_nettype wire

// File: test/eldu_look_checker.sv
// Scoreboard for the look direction unit: predicts each result from accepted
// transfers and register writes, compares outputs field by field. Needs eldu_pkg.
`timescale 1ns / 100ps
module eldu_look_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [eldu_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    input  wire logic                         pready,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [1:0]                   command,
    input  wire logic signed [15:0]           delta_x,
    input  wire logic signed [15:0]           delta_y,
    input  wire logic                         clamp_enable,
    input  wire logic signed [31:0]           angle_value,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic signed [31:0]           yaw_out,
    input  wire logic signed [31:0]           pitch_out,
    input  wire logic signed [15:0]           front_x,
    input  wire logic signed [15:0]           front_y,
    input  wire logic signed [15:0]           front_z,
    input  wire logic signed [15:0]           right_x,
    input  wire logic signed [15:0]           right_y,
    input  wire logic signed [15:0]           right_z,
    input  wire logic signed [15:0]           up_x,
    input  wire logic signed [15:0]           up_y,
    input  wire logic signed [15:0]           up_z,
    input  wire logic                         degenerate,
    output int                                fail_count,
    output int                                pending_count
);
    import eldu_pkg::*;

    localparam longint A90  = 64'sd5898240;
    localparam longint A360 = 64'sd23592960;
    localparam longint ALIM = 64'sd5898174;

    typedef struct packed {
        logic signed [31:0] yaw;
        logic signed [31:0] pitch;
        logic [8:0][15:0]   vec;
        logic               degen;
    } orient_t;

    orient_t     orient_q[$];
    longint      yaw_acc;
    longint      pitch_acc;
    logic [15:0] gain;

    string vec_name[9] = '{"front_x", "front_y", "front_z", "right_x", "right_y",
                           "right_z", "up_x", "up_y", "up_z"};

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint wrap360(longint a);
        longint r;
        r = a % A360;
        if (r < 0)
            r += A360;
        return r;
    endfunction

    // Round to Q2.14 half up from a value with sh fraction bits, then clamp.
    function automatic logic [15:0] round_q14(longint v, int sh);
        longint unsigned bias;
        longint unsigned u;
        longint          r;
        bias = 64'd1 << 62;
        u = longint'(v) + bias + (64'd1 << (sh - 1));
        r = longint'(u >> sh) - longint'(bias >> sh);
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    // Sine and cosine in Q1.30 of an angle already reduced into [0, 360).
    function automatic void cordic_sincos(input longint r, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit     flip;
        x = 64'sd652032875;
        y = 0;
        flip = 0;
        if (r <= A90)
            z = r;
        else if (r < 3 * A90) begin
            z = r - 2 * A90;
            flip = 1;
        end
        else
            z = r - A360;
        for (int i = 0; i < 17; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(atan_deg(i[4:0]));
            end
            else begin
                x += dx;
                y -= dy;
                z += longint'(atan_deg(i[4:0]));
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    // Apply one command to the angles and derive the camera basis.
    function automatic orient_t advance_orientation(logic [1:0] cmd, logic signed [15:0] dxi,
                                                    logic signed [15:0] dyi, logic clamp,
                                                    logic signed [31:0] ang);
        orient_t o;
        longint  ry, rp, sy, cy, sp, cp, sg;
        bit      dg;
        if (cmd == CMD_LOOK) begin
            yaw_acc   = sat32(yaw_acc + longint'(dxi) * longint'(gain));
            pitch_acc = sat32(pitch_acc + longint'(dyi) * longint'(gain));
            if (clamp) begin
                if (pitch_acc > ALIM)
                    pitch_acc = ALIM;
                if (pitch_acc < -ALIM)
                    pitch_acc = -ALIM;
            end
            yaw_acc = yaw_acc % A360;
        end
        else if (cmd == CMD_SET_YAW)
            yaw_acc = longint'(ang);
        else if (cmd == CMD_SET_PITCH)
            pitch_acc = longint'(ang);
        ry = wrap360(yaw_acc);
        rp = wrap360(pitch_acc);
        cordic_sincos(ry, sy, cy);
        cordic_sincos(rp, sp, cp);
        dg = (rp == A90) || (rp == 3 * A90);
        sg = (!dg && rp > A90 && rp < 3 * A90) ? -1 : 1;
        o.yaw    = yaw_acc[31:0];
        o.pitch  = pitch_acc[31:0];
        o.vec[0] = round_q14(cy * cp, 46);
        o.vec[1] = round_q14(sp, 16);
        o.vec[2] = round_q14(sy * cp, 46);
        o.vec[3] = round_q14(-sg * sy, 16);
        o.vec[4] = 16'd0;
        o.vec[5] = round_q14(sg * cy, 16);
        o.vec[6] = round_q14(-sg * cy * sp, 46);
        o.vec[7] = round_q14(sg * cp, 16);
        o.vec[8] = round_q14(-sg * sy * sp, 46);
        o.degen  = dg;
        return o;
    endfunction

    assign pending_count = orient_q.size();

    always @(posedge clk or negedge rst_n) begin
        orient_t          exp_o;
        logic [8:0][15:0] got;
        if (!rst_n) begin
            yaw_acc    = 0;
            pitch_acc  = 0;
            gain       = LOOK_GAIN_RESET;
            fail_count = 0;
            orient_q.delete();
        end
        else begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_LOOK_GAIN)
                gain = pwdata[15:0];
            if (in_valid && in_ready)
                orient_q.push_back(advance_orientation(command, delta_x, delta_y,
                                                       clamp_enable, angle_value));
            if (out_valid && out_ready) begin
                got = {up_z, up_y, up_x, right_z, right_y, right_x, front_z, front_y, front_x};
                if (orient_q.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    fail_count++;
                end
                else begin
                    exp_o = orient_q.pop_front();
                    if (yaw_out !== exp_o.yaw) begin
                        $error("yaw_out expected %0d actual %0d", exp_o.yaw, yaw_out);
                        fail_count++;
                    end
                    if (pitch_out !== exp_o.pitch) begin
                        $error("pitch_out expected %0d actual %0d", exp_o.pitch, pitch_out);
                        fail_count++;
                    end
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== exp_o.vec[i]) begin
                            $error("%s expected %0d actual %0d", vec_name[i],
                                   $signed(exp_o.vec[i]), $signed(got[i]));
                            fail_count++;
                        end
                    if (degenerate !== exp_o.degen) begin
                        $error("degenerate expected %0d actual %0d", exp_o.degen, degenerate);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// File: test/tb.sv
// Testbench top for the look direction unit: clock, reset, stimulus, verdict.
// Needs eldu_pkg, euler_look_direction_unit and eldu_look_checker.
`timescale 1ns / 100ps
module tb;
    import eldu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  psel, penable, pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid, in_ready;
    logic [1:0]            command;
    logic signed [15:0]    delta_x, delta_y;
    logic                  clamp_enable;
    logic signed [31:0]    angle_value;
    logic                  out_valid, out_ready;
    logic signed [31:0]    yaw_out, pitch_out;
    logic signed [15:0]    front_x, front_y, front_z;
    logic signed [15:0]    right_x, right_y, right_z;
    logic signed [15:0]    up_x, up_y, up_z;
    logic                  degenerate;
    int                    fail_count;
    int                    pending_count;
    int                    cycle_count;
    bit                    steady;   // suppress idling on both sides

    euler_look_direction_unit u_top (.*);

    eldu_look_checker u_chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: end the run with a failure once the cycle count passes CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: drop ready about a quarter of the time unless steady.
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 25);

    // Write one register: setup cycle, then access cycle.
    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold until every expected result has been transferred.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Present one command and hold it until transfer; then maybe idle.
    task automatic send_cmd(logic [1:0] cmd, logic [15:0] dx, logic [15:0] dy, logic clamp,
                            logic [31:0] ang);
        in_valid     <= 1'b1;
        command      <= cmd;
        delta_x      <= dx;
        delta_y      <= dy;
        clamp_enable <= clamp;
        angle_value  <= ang;
        do
            @(posedge clk);
        while (!in_ready);
        if (!steady && $urandom_range(99) < 25) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    endtask

    // Random angle: full range, at or near a multiple of a right angle, or small.
    function automatic logic [31:0] pick_angle();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return DEG90 * ($urandom_range(8) - 4);
            2:       return DEG90 * ($urandom_range(8) - 4) + ($urandom_range(6) - 3);
            default: return $urandom_range(DEG360) - DEG180;
        endcase
    endfunction

    function automatic logic [15:0] pick_delta();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(200) - 100);
    endfunction

    task automatic random_phase(int n);
        logic [1:0] cmd;
        int         r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            cmd = (r < 60) ? CMD_LOOK : (r < 78) ? CMD_SET_YAW :
                  (r < 95) ? CMD_SET_PITCH : CMD_UNUSED;
            send_cmd(cmd, pick_delta(), pick_delta(), 1'($urandom_range(1)), pick_angle());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        command      = CMD_LOOK;
        delta_x      = '0;
        delta_y      = '0;
        clamp_enable = 1'b0;
        angle_value  = '0;
        out_ready    = 1'b0;
        cycle_count  = 0;
        steady       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every command, degenerate pitch, unused code.
        send_cmd(CMD_LOOK, 16'sd0, 16'sd0, 1'b0, 32'd0);
        send_cmd(CMD_LOOK, 16'sh7fff, 16'sh7fff, 1'b1, 32'd0);
        send_cmd(CMD_LOOK, 16'sh8000, 16'sh8000, 1'b1, 32'd0);
        send_cmd(CMD_SET_PITCH, '0, '0, 1'b0, DEG90);
        send_cmd(CMD_SET_PITCH, '0, '0, 1'b0, DEG270);
        send_cmd(CMD_SET_PITCH, '0, '0, 1'b0, -DEG90);
        send_cmd(CMD_SET_PITCH, '0, '0, 1'b0, DEG180);
        send_cmd(CMD_SET_YAW, '0, '0, 1'b0, 32'sh7fffffff);
        send_cmd(CMD_SET_YAW, '0, '0, 1'b0, 32'sh80000000);
        send_cmd(CMD_SET_PITCH, '0, '0, 1'b0, 32'sh7fffffff);
        send_cmd(CMD_UNUSED, 16'sh7fff, 16'sh8000, 1'b1, 32'hffffffff);
        drain();

        // Saturate the accumulators with the largest gain; probe ignored index too.
        reg_write(PADDR_W'(4), 32'hffffffff);
        reg_write(PADDR_W'(0), 32'h0000ffff);
        for (int i = 0; i < 4; i++)
            send_cmd(CMD_LOOK, 16'sh7fff, 16'sh7fff, 1'b0, 32'd0);
        for (int i = 0; i < 4; i++)
            send_cmd(CMD_LOOK, 16'sh8000, 16'sh8000, 1'b0, 32'd0);
        send_cmd(CMD_LOOK, 16'sh0001, 16'sh7fff, 1'b1, 32'd0);
        drain();

        // Random phases across gain settings, one with no idling at all.
        reg_write(PADDR_W'(0), 32'd0);
        random_phase(120);
        drain();
        reg_write(PADDR_W'(0), 32'h0000ffff);
        random_phase(150);
        drain();
        reg_write(PADDR_W'(0), 32'd6554);
        steady = 1'b1;
        random_phase(180);
        steady = 1'b0;
        drain();
        reg_write(PADDR_W'(0), {16'd0, 16'($urandom)});
        random_phase(180);
        drain();
        reg_write(PADDR_W'(0), 32'd1);
        random_phase(170);
        drain();

        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
